>>> hw/rtl/rse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg: shared types, constants and microcode for the RPN stack evaluator
// Beat types, command codes, divider handshake and the control-word table.
// ----------------------------------------------------------------------------
package rse_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Q16.16 format and divider sizing
    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int DVD_W     = Q_W + FRAC_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
    localparam logic signed [63:0] RND_HALF = 64'sd32768;

    // Token codes
    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_PRINT   = 3'd5,
        CMD_UNKNOWN = 3'd6
    } t_cmd;

    // Input and result beats
    typedef struct packed {
        logic [2:0]        command;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] shown_value;
        logic              shown;
        logic              underflow;
        logic              overflow;
        logic              divide_by_zero;
        logic              unknown_command;
        logic              saturated;
    } t_out;

    // Divider handshake
    typedef struct packed {
        logic              start;
        logic signed [31:0] dividend;
        logic signed [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              neg;
        logic [DVD_W-1:0]  quotient;
    } t_div_rsp;

    // Microcode control word
    typedef enum logic [4:0] {
        ACT_NOP,
        ACT_PUSH_IN,
        ACT_POP,
        ACT_LATCH_B,
        ACT_LATCH_A,
        ACT_ADD,
        ACT_SUB,
        ACT_MUL,
        ACT_MAG,
        ACT_RND,
        ACT_SGN,
        ACT_CLAMP_PUSH,
        ACT_DIV_START,
        ACT_DIV_DONE,
        ACT_DIVZ,
        ACT_SHOW,
        ACT_UNK
    } t_act;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JMP,
        SEQ_JOP,
        SEQ_JBZ,
        SEQ_WAIT,
        SEQ_END
    } t_seq;

    localparam int PC_W = 5;

    typedef struct packed {
        t_act            act;
        t_seq            seq;
        logic [PC_W-1:0] target;
    } t_uop;

    // Program entry points
    localparam logic [PC_W-1:0] PC_PUSH     = 5'd0;
    localparam logic [PC_W-1:0] PC_BIN      = 5'd1;
    localparam logic [PC_W-1:0] PC_ADD      = 5'd5;
    localparam logic [PC_W-1:0] PC_SUB      = 5'd6;
    localparam logic [PC_W-1:0] PC_MUL      = 5'd7;
    localparam logic [PC_W-1:0] PC_CLAMP    = 5'd11;
    localparam logic [PC_W-1:0] PC_DIV      = 5'd12;
    localparam logic [PC_W-1:0] PC_DIV_WAIT = 5'd18;
    localparam logic [PC_W-1:0] PC_DIVZ     = 5'd20;
    localparam logic [PC_W-1:0] PC_PRINT    = 5'd21;
    localparam logic [PC_W-1:0] PC_UNK      = 5'd23;
    localparam logic [PC_W-1:0] PC_NONE     = 5'd0;

    // Control store
    function automatic t_uop f_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            5'd0:    u = '{ACT_PUSH_IN,    SEQ_END,  PC_NONE};
            5'd1:    u = '{ACT_POP,        SEQ_NEXT, PC_NONE};
            5'd2:    u = '{ACT_LATCH_B,    SEQ_NEXT, PC_NONE};
            5'd3:    u = '{ACT_POP,        SEQ_NEXT, PC_NONE};
            5'd4:    u = '{ACT_LATCH_A,    SEQ_JOP,  PC_NONE};
            5'd5:    u = '{ACT_ADD,        SEQ_JMP,  PC_CLAMP};
            5'd6:    u = '{ACT_SUB,        SEQ_JMP,  PC_CLAMP};
            5'd7:    u = '{ACT_MUL,        SEQ_NEXT, PC_NONE};
            5'd8:    u = '{ACT_MAG,        SEQ_NEXT, PC_NONE};
            5'd9:    u = '{ACT_RND,        SEQ_NEXT, PC_NONE};
            5'd10:   u = '{ACT_SGN,        SEQ_JMP,  PC_CLAMP};
            5'd11:   u = '{ACT_CLAMP_PUSH, SEQ_END,  PC_NONE};
            5'd12:   u = '{ACT_POP,        SEQ_NEXT, PC_NONE};
            5'd13:   u = '{ACT_LATCH_B,    SEQ_NEXT, PC_NONE};
            5'd14:   u = '{ACT_NOP,        SEQ_JBZ,  PC_DIVZ};
            5'd15:   u = '{ACT_POP,        SEQ_NEXT, PC_NONE};
            5'd16:   u = '{ACT_LATCH_A,    SEQ_NEXT, PC_NONE};
            5'd17:   u = '{ACT_DIV_START,  SEQ_NEXT, PC_NONE};
            5'd18:   u = '{ACT_NOP,        SEQ_WAIT, PC_NONE};
            5'd19:   u = '{ACT_DIV_DONE,   SEQ_JMP,  PC_CLAMP};
            5'd20:   u = '{ACT_DIVZ,       SEQ_END,  PC_NONE};
            5'd21:   u = '{ACT_POP,        SEQ_NEXT, PC_NONE};
            5'd22:   u = '{ACT_SHOW,       SEQ_END,  PC_NONE};
            default: u = '{ACT_UNK,        SEQ_END,  PC_NONE};
        endcase
        return u;
    endfunction

    // Entry step for a token
    function automatic logic [PC_W-1:0] f_entry(input logic [2:0] cmd);
        logic [PC_W-1:0] pc;
        case (cmd)
            CMD_PUSH:  pc = PC_PUSH;
            CMD_ADD:   pc = PC_BIN;
            CMD_SUB:   pc = PC_BIN;
            CMD_MUL:   pc = PC_BIN;
            CMD_DIV:   pc = PC_DIV;
            CMD_PRINT: pc = PC_PRINT;
            default:   pc = PC_UNK;
        endcase
        return pc;
    endfunction

    // Operator step after both operands are in
    function automatic logic [PC_W-1:0] f_op_target(input logic [2:0] cmd);
        logic [PC_W-1:0] pc;
        case (cmd)
            CMD_ADD: pc = PC_ADD;
            CMD_SUB: pc = PC_SUB;
            default: pc = PC_MUL;
        endcase
        return pc;
    endfunction

    function automatic logic signed [63:0] f_sext(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rse_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/rse_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_div: iterative Q16.16 divider
// Restoring division of |dividend| * 2^16 by |divisor|, one quotient bit
// per cycle; the sign is returned beside the magnitude.
// ----------------------------------------------------------------------------
module rse_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rse_pkg::t_div_req i_req,
    output rse_pkg::t_div_rsp      o_rsp
);
    import rse_pkg::*;

    logic              r_busy;
    logic              r_neg;
    logic [DCNT_W-1:0] r_cnt;
    logic [Q_W-1:0]    r_dvs;
    logic [Q_W-1:0]    r_rem;
    logic [DVD_W-1:0]  r_quo;

    logic [Q_W:0]      a_ext;
    logic [Q_W:0]      b_ext;
    logic [Q_W-1:0]    a_mag;
    logic [Q_W-1:0]    b_mag;
    logic [Q_W:0]      shifted;
    logic              ge;
    logic [Q_W:0]      diff;

    // Operand magnitudes
    always_comb begin
        a_ext = {i_req.dividend[31], i_req.dividend};
        b_ext = {i_req.divisor[31], i_req.divisor};
        a_mag = i_req.dividend[31] ? Q_W'(-a_ext) : Q_W'(a_ext);
        b_mag = i_req.divisor[31]  ? Q_W'(-b_ext) : Q_W'(b_ext);
    end

    // One trial subtraction per cycle
    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        ge      = (shifted >= {1'b0, r_dvs});
        diff    = shifted - {1'b0, r_dvs};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[31] ^ i_req.divisor[31];
            r_dvs <= b_mag;
            r_rem <= '0;
            r_quo <= {a_mag, {FRAC_W{1'b0}}};
        end else if (r_busy) begin
            r_rem <= ge ? diff[Q_W-1:0] : shifted[Q_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.neg      = r_neg;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

>>> hw/rtl/rpn_stack_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: reverse Polish calculator over signed Q16.16 values
// A microcoded sequencer steps a small datapath over an operand stack RAM.
// ----------------------------------------------------------------------------
// One token is in flight at a time; division runs in the one-bit-per-cycle
// divider. The next beat is taken the cycle after the result is loaded into
// the output register.
// Reset (synchronous, active low) empties the stack and drops any pending
// result; the stack RAM itself is not cleared.
module rpn_stack_evaluator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rse_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rse_pkg::t_out      o_out
);
    import rse_pkg::*;

    // Sequencer state
    logic              r_busy;
    logic [PC_W-1:0]   r_pc,  n_pc;
    logic [2:0]        r_cmd;
    logic signed [31:0] r_val;

    // Datapath
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_rd_ok, n_rd_ok;
    logic signed [31:0] r_a, n_a;
    logic signed [31:0] r_b, n_b;
    logic signed [63:0] r_acc, n_acc;
    logic              r_neg, n_neg;

    // Per-token status
    logic              r_unf, n_unf;
    logic              r_ovf, n_ovf;
    logic              r_sat, n_sat;
    logic              r_dz,  n_dz;
    logic              r_unk, n_unk;
    logic              r_shown, n_shown;
    logic signed [31:0] r_shv, n_shv;

    // Output register
    logic              r_ov;
    t_out              r_out;

    t_uop              uop;
    logic              in_fire;
    logic              go;
    logic              last;
    logic [CNT_W-1:0]  cnt_m1;
    logic signed [63:0] prod;
    logic signed [63:0] clamped;
    logic [Q_W-1:0]    rdata;
    logic              we;
    logic [Q_W-1:0]    wdata;
    logic              re;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign uop        = f_rom(r_pc);
    assign o_in_ready = !r_busy;
    assign in_fire    = i_in_valid && o_in_ready;
    // Hold a final step until the output register can take the result
    assign go         = r_busy && !(uop.seq == SEQ_END && r_ov && !i_out_ready);
    assign last       = go && (uop.seq == SEQ_END);
    assign cnt_m1     = r_cnt - CNT_W'(1);
    assign prod       = r_a * r_b;

    always_comb begin
        if (r_acc > Q_MAX) begin
            clamped = Q_MAX;
        end else if (r_acc < Q_MIN) begin
            clamped = Q_MIN;
        end else begin
            clamped = r_acc;
        end
    end

    // Execute the current control word
    always_comb begin
        n_cnt   = r_cnt;
        n_rd_ok = r_rd_ok;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_unf   = r_unf;
        n_ovf   = r_ovf;
        n_sat   = r_sat;
        n_dz    = r_dz;
        n_unk   = r_unk;
        n_shown = r_shown;
        n_shv   = r_shv;
        we      = 1'b0;
        wdata   = r_val;
        re      = 1'b0;
        div_req = '{1'b0, r_a, r_b};
        if (go) begin
            case (uop.act)
                ACT_PUSH_IN: begin
                    if (r_cnt >= CNT_W'(STACK_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        we    = 1'b1;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                ACT_POP: begin
                    if (r_cnt == '0 || r_cnt > CNT_W'(STACK_DEPTH)) begin
                        n_unf   = 1'b1;
                        n_cnt   = '0;
                        n_rd_ok = 1'b0;
                    end else begin
                        re      = 1'b1;
                        n_cnt   = cnt_m1;
                        n_rd_ok = 1'b1;
                    end
                end
                ACT_LATCH_B: n_b = r_rd_ok ? $signed(rdata) : 32'sd0;
                ACT_LATCH_A: n_a = r_rd_ok ? $signed(rdata) : 32'sd0;
                ACT_ADD:     n_acc = f_sext(r_a) + f_sext(r_b);
                ACT_SUB:     n_acc = f_sext(r_a) - f_sext(r_b);
                ACT_MUL:     n_acc = prod;
                ACT_MAG: begin
                    n_neg = r_acc[63];
                    n_acc = r_acc[63] ? -r_acc : r_acc;
                end
                ACT_RND:     n_acc = (r_acc + RND_HALF) >>> FRAC_W;
                ACT_SGN:     n_acc = r_neg ? -r_acc : r_acc;
                ACT_CLAMP_PUSH: begin
                    n_sat = (r_acc > Q_MAX) || (r_acc < Q_MIN);
                    wdata = clamped[31:0];
                    if (r_cnt >= CNT_W'(STACK_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        we    = 1'b1;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                ACT_DIV_START: div_req.start = 1'b1;
                ACT_DIV_DONE: begin
                    n_acc = div_rsp.neg ? -$signed({16'b0, div_rsp.quotient})
                                        :  $signed({16'b0, div_rsp.quotient});
                end
                ACT_DIVZ:    n_dz = 1'b1;
                ACT_SHOW: begin
                    n_shown = 1'b1;
                    n_shv   = r_rd_ok ? $signed(rdata) : 32'sd0;
                end
                ACT_UNK:     n_unk = 1'b1;
                default: begin
                end
            endcase
        end
    end

    // Pick the next step
    always_comb begin
        n_pc = r_pc;
        if (go) begin
            case (uop.seq)
                SEQ_NEXT: n_pc = r_pc + PC_W'(1);
                SEQ_JMP:  n_pc = uop.target;
                SEQ_JOP:  n_pc = f_op_target(r_cmd);
                SEQ_JBZ:  n_pc = (r_b == 32'sd0) ? uop.target : r_pc + PC_W'(1);
                SEQ_WAIT: n_pc = div_rsp.busy ? r_pc : r_pc + PC_W'(1);
                SEQ_END:  n_pc = r_pc;
                default:  n_pc = r_pc;
            endcase
        end
    end

    // Sequencer and stack count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_PUSH;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (in_fire) begin
                r_busy <= 1'b1;
                r_pc   <= f_entry(i_in.command);
            end else begin
                r_pc <= n_pc;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Working registers; clear status on a new beat
    always_ff @(posedge i_clk) begin
        r_rd_ok <= n_rd_ok;
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        if (in_fire) begin
            r_cmd   <= i_in.command;
            r_val   <= i_in.value;
            r_unf   <= 1'b0;
            r_ovf   <= 1'b0;
            r_sat   <= 1'b0;
            r_dz    <= 1'b0;
            r_unk   <= 1'b0;
            r_shown <= 1'b0;
            r_shv   <= 32'sd0;
        end else begin
            r_unf   <= n_unf;
            r_ovf   <= n_ovf;
            r_sat   <= n_sat;
            r_dz    <= n_dz;
            r_unk   <= n_unk;
            r_shown <= n_shown;
            r_shv   <= n_shv;
        end
    end

    // Output register: load on the final step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (last) begin
            r_ov <= 1'b1;
        end else if (r_ov && i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last) begin
            r_out <= '{n_shv, n_shown, n_unf, n_ovf, n_dz, n_unk, n_sat};
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    rse_ram #(
        .WIDTH (Q_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (cnt_m1[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    rse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Stack count stays within the stack
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // An accepted beat starts the sequencer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_busy)
        else $error("sequencer did not start on accepted beat");

    // The divider only runs while the sequencer waits on it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> (r_busy && r_pc == PC_DIV_WAIT))
        else $error("divider busy outside its wait step");

    // A shown value comes only from a print token
    a_shown_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last && n_shown |-> r_cmd == CMD_PRINT)
        else $error("shown flag on a non-print token");

    // Overflow and divide-by-zero never come together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_out.overflow && r_out.divide_by_zero))
        else $error("overflow with divide by zero");

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RPN stack evaluator
// Feeds push, operator, print and unknown tokens through the valid/ready input.
// A behavioral copy of the Q16.16 operand stack predicts each result beat.
// The output side is checked field by field against the oldest prediction.
// Both sides idle at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import rse_pkg::*;

    // Spare selector code that the block must treat as unknown
    localparam logic [2:0] CMD_SPARE = 3'd7;

    localparam int ITEMS_TARGET = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_PRINTS   = 40;

    localparam logic signed [31:0] QV_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QV_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] QV_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] QV_MONE = 32'shFFFF_0000;
    localparam logic signed [31:0] QV_HALF = 32'sh0000_8000;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic in_valid   = 1'b0;
    t_in  in_beat    = '0;
    logic out_ready  = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    // Operand stack as the block should see it
    logic signed [31:0] model_stack [STACK_DEPTH];
    int                 model_depth = 0;
    t_out               pending_results [$];

    int   err_count    = 0;
    int   tokens_sent  = 0;
    int   results_seen = 0;

    // Sender burst state
    bit   tx_gaps_on = 1'b1;
    int   burst_left = 0;

    // Receiver stall state
    logic hold_tgl  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;
    int   rx_mode   = 0;
    int unsigned rx_cycle = 0;

    rpn_stack_evaluator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Run-away guard
    initial begin
        #(64'd20_000_000);
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic report_err(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("tb_top: mismatch at result %0d: %s", results_seen, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Stack calculator
    // ------------------------------------------------------------------
    function automatic logic signed [63:0] pop_operand(inout logic uf);
        if (model_depth == 0) begin
            uf = 1'b1;
            return 64'sd0;
        end
        model_depth--;
        return model_stack[model_depth];
    endfunction

    function automatic void push_operand(input logic signed [63:0] v, inout logic ov);
        if (model_depth >= STACK_DEPTH) begin
            ov = 1'b1;
            return;
        end
        model_stack[model_depth] = v[31:0];
        model_depth++;
    endfunction

    function automatic logic signed [63:0] saturate_q(input logic signed [63:0] v,
                                                      inout logic sat);
        if (v > Q_MAX) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // Compute the result beat of one token and advance the stack
    task automatic evaluate_token(input t_in beat);
        t_out               r;
        logic               uf;
        logic               ov;
        logic               sat;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        logic signed [63:0] acc;
        logic [63:0]        mag;
        logic               neg;
        r   = '0;
        uf  = 1'b0;
        ov  = 1'b0;
        sat = 1'b0;
        lhs = beat.value;
        case (beat.command)
            CMD_PUSH: begin
                push_operand(lhs, ov);
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                rhs = pop_operand(uf);
                lhs = pop_operand(uf);
                if (beat.command == CMD_ADD) begin
                    acc = lhs + rhs;
                end else if (beat.command == CMD_SUB) begin
                    acc = lhs - rhs;
                end else begin
                    // Scale the product by 2^-16, round half away from zero
                    acc = lhs * rhs;
                    neg = acc < 0;
                    mag = neg ? -acc : acc;
                    mag = (mag + 64'd32768) >> 16;
                    acc = neg ? -$signed(mag) : $signed(mag);
                end
                push_operand(saturate_q(acc, sat), ov);
            end
            CMD_DIV: begin
                rhs = pop_operand(uf);
                if (rhs == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    lhs = pop_operand(uf);
                    acc = (lhs <<< 16) / rhs;
                    push_operand(saturate_q(acc, sat), ov);
                end
            end
            CMD_PRINT: begin
                lhs           = pop_operand(uf);
                r.shown       = 1'b1;
                r.shown_value = lhs[31:0];
            end
            default: begin
                r.unknown_command = 1'b1;
            end
        endcase
        r.underflow = uf;
        r.overflow  = ov;
        r.saturated = sat;
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Input side: offer one beat, hold it until taken
    // ------------------------------------------------------------------
    task automatic send_token(input logic [2:0] cmd, input logic signed [31:0] val);
        t_in beat;
        int  gap;
        beat.command = cmd;
        beat.value   = val;
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70)
                                                  : $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        evaluate_token(beat);
        tokens_sent++;
    endtask

    function automatic logic signed [31:0] rand_operand();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = QV_MAX;
            1:       v = QV_MIN;
            2:       v = '0;
            3:       v = $signed($urandom_range(0, 40) << 16) * ($urandom_range(0, 1) ? 1 : -1);
            4:       v = $signed($urandom_range(0, 32'h1_FFFF)) * ($urandom_range(0, 1) ? 1 : -1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall pattern and a long hold on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 150 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        if (hold_tgl != hold_ack) begin
            hold_ack  <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= (rx_cycle[1:0] == 2'b11);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Check each result beat against the oldest prediction
    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_err($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_err("result beat with nothing expected");
            end else begin
                want = pending_results.pop_front();
                compare_field("shown_value", o_out.shown_value, want.shown_value);
                compare_field("shown", 32'(o_out.shown), 32'(want.shown));
                compare_field("underflow", 32'(o_out.underflow), 32'(want.underflow));
                compare_field("overflow", 32'(o_out.overflow), 32'(want.overflow));
                compare_field("divide_by_zero", 32'(o_out.divide_by_zero),
                              32'(want.divide_by_zero));
                compare_field("unknown_command", 32'(o_out.unknown_command),
                              32'(want.unknown_command));
                compare_field("saturated", 32'(o_out.saturated), 32'(want.saturated));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, each operator and each corner of the stack rules
    task automatic test_corners();
        // empty-stack pops
        send_token(CMD_PRINT, QV_MAX);
        send_token(CMD_ADD, '0);
        send_token(CMD_DIV, '0);
        send_token(CMD_DIV, '1);
        // saturating add and subtract
        send_token(CMD_PUSH, QV_MAX);
        send_token(CMD_PUSH, QV_MAX);
        send_token(CMD_ADD, '0);
        send_token(CMD_PUSH, QV_MIN);
        send_token(CMD_SUB, '0);
        send_token(CMD_PRINT, '0);
        // multiply ties round away from zero
        send_token(CMD_PUSH, QV_HALF);
        send_token(CMD_PUSH, 32'sd1);
        send_token(CMD_MUL, '0);
        send_token(CMD_PUSH, -QV_HALF);
        send_token(CMD_PUSH, 32'sd1);
        send_token(CMD_MUL, '0);
        send_token(CMD_PUSH, QV_MAX);
        send_token(CMD_MUL, '0);
        // divide: overflowing quotient, truncation, zero divisor
        send_token(CMD_PUSH, QV_MIN);
        send_token(CMD_PUSH, QV_MONE);
        send_token(CMD_DIV, '0);
        send_token(CMD_PUSH, 32'sd7);
        send_token(CMD_PUSH, -32'sd2 * QV_ONE);
        send_token(CMD_DIV, '0);
        send_token(CMD_PUSH, '0);
        send_token(CMD_DIV, '0);
        send_token(CMD_UNKNOWN, QV_MIN);
        send_token(CMD_SPARE, QV_MAX);
    endtask

    // Fill past the top, then drain past the bottom
    task automatic test_full_stack();
        repeat (STACK_DEPTH - model_depth + 2) send_token(CMD_PUSH, rand_operand());
        send_token(CMD_ADD, $urandom);
        send_token(CMD_PUSH, rand_operand());
        send_token(CMD_PUSH, rand_operand());
        while (model_depth != 0) send_token(CMD_PRINT, $urandom);
        send_token(CMD_PRINT, $urandom);
    endtask

    // Hold the output off while the input keeps offering beats
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_tgl  <= ~hold_tgl;
        repeat (12) begin
            send_token(CMD_PUSH, rand_operand());
            send_token(CMD_PRINT, $urandom);
        end
        tx_gaps_on = 1'b1;
    endtask

    // Mostly well-formed expressions with random operands, some noise
    task automatic test_random_expressions();
        int          pick;
        int          push_pct;
        logic [2:0]  op;
        while (tokens_sent < ITEMS_TARGET) begin
            if ($urandom_range(0, 149) == 0) begin
                tx_gaps_on = ~tx_gaps_on;
            end
            pick     = $urandom_range(0, 199);
            push_pct = (model_depth < 2) ? 100 : ((model_depth > 24) ? 30 : 55);
            if (pick == 0) begin
                // run the stack up to full and one past
                while (model_depth < STACK_DEPTH) send_token(CMD_PUSH, rand_operand());
                send_token(CMD_PUSH, rand_operand());
            end else if (pick < 8) begin
                send_token($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_SPARE, $urandom);
            end else if (pick < 20) begin
                send_token(3'($urandom_range(CMD_ADD, CMD_PRINT)), $urandom);
            end else if ($urandom_range(0, 99) < push_pct) begin
                send_token(CMD_PUSH, rand_operand());
            end else begin
                case ($urandom_range(0, 4))
                    0:       op = CMD_ADD;
                    1:       op = CMD_SUB;
                    2:       op = CMD_MUL;
                    3:       op = CMD_DIV;
                    default: op = CMD_PRINT;
                endcase
                send_token(op, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_full_stack();
        test_backpressure();
        test_random_expressions();

        // Drop valid and let the last results drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
